@@ rtl/upq_pkg.sv @@
package upq_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int ENTRY_W  = 7;
   localparam int STATUS_W = 2;
   localparam int RSP_DATA_W = ((VALUE_W + ENTRY_W + 7) / 8) * 8;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

@@ rtl/upq_ram.sv @@
module upq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/unsorted_min_priority_queue_unit.sv @@
// Min-priority queue of signed 32-bit values held unsorted in one RAM.
// Request channel (req_*): tuser[0] selects insert (0) or remove-min (1),
// tdata[31:0] carries the value to insert. One request is taken at a time;
// req_tready is high only while the unit is idle.
// Response channel (rsp_*): one response per request. tuser carries the
// status (ok, remove on empty, insert on full); tdata carries the removed
// minimum (zero otherwise) and the entry count after the request.
// Sequence: an insert and the empty/full cases go from acceptance straight to
// the DONE state, which loads the response register. A remove-min reads every
// stored entry through the single RAM read port, one per cycle, then writes the
// last entry into the freed slot (states SCAN, DRAIN, WRITE, DONE).
// The response sits in an output register; the next request is taken while
// it waits. If the receiver stalls with a response still held, a finished
// request waits in the unit and no further request is taken.
// Reset (synchronous, active high) empties the queue and drops any pending
// response; no clearing pass is needed.
module unsorted_min_priority_queue_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [upq_pkg::VALUE_W-1:0]    req_tdata,  // item_value
   input  logic                           req_tuser,  // req_type
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [upq_pkg::RSP_DATA_W-1:0] rsp_tdata,  // min_value, entry_count, pad
   output logic [upq_pkg::STATUS_W-1:0]   rsp_tuser   // status
);

   upq_pkg::state_type state_ff, state_in;

   logic [upq_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic [upq_pkg::ADDR_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [upq_pkg::ADDR_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [upq_pkg::ADDR_W-1:0]   best_idx_ff, best_idx_in;
   logic signed [upq_pkg::VALUE_W-1:0] best_ff, best_in;
   logic [upq_pkg::VALUE_W-1:0]  last_ff, last_in;
   logic [upq_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [upq_pkg::VALUE_W-1:0]  res_value_ff, res_value_in;
   logic [upq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [upq_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [upq_pkg::ENTRY_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                         req_fire;
   logic                         out_free;
   logic [upq_pkg::ADDR_W-1:0]   last_idx;
   logic                         mem_wr_en;
   logic [upq_pkg::ADDR_W-1:0]   mem_wr_addr;
   logic [upq_pkg::VALUE_W-1:0]  mem_wr_data;
   logic                         mem_rd_en;
   logic [upq_pkg::VALUE_W-1:0]  mem_rd_data;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign last_idx = upq_pkg::ADDR_W'(count_ff - upq_pkg::CNT_W'(1));

   upq_ram #(
      .WIDTH(upq_pkg::VALUE_W),
      .DEPTH(upq_pkg::CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(scan_idx_ff),
      .rd_data(mem_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         upq_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == upq_pkg::REQ_REMOVE && count_ff != '0) begin
                  state_in = upq_pkg::ST_SCAN;
               end else begin
                  state_in = upq_pkg::ST_DONE;
               end
            end
         end
         upq_pkg::ST_SCAN: begin
            if (scan_idx_ff == last_idx) begin
               state_in = upq_pkg::ST_DRAIN;
            end
         end
         upq_pkg::ST_DRAIN: state_in = upq_pkg::ST_WRITE;
         upq_pkg::ST_WRITE: state_in = upq_pkg::ST_DONE;
         upq_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = upq_pkg::ST_IDLE;
            end
         end
         default: state_in = upq_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready  = 1'b0;
      mem_rd_en   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = best_idx_ff;
      mem_wr_data = last_ff;
      case (state_ff)
         upq_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            mem_wr_addr = upq_pkg::ADDR_W'(count_ff);
            mem_wr_data = req_tdata;
            mem_wr_en   = req_fire && req_tuser == upq_pkg::REQ_INSERT
                          && count_ff != upq_pkg::CNT_W'(upq_pkg::CAPACITY);
         end
         upq_pkg::ST_SCAN:  mem_rd_en = 1'b1;
         upq_pkg::ST_WRITE: mem_wr_en = 1'b1;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      rd_idx_in     = scan_idx_ff;
      rd_valid_in   = (state_ff == upq_pkg::ST_SCAN);
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      last_in       = last_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;

      if (state_ff == upq_pkg::ST_IDLE && req_fire) begin
         res_value_in  = '0;
         res_status_in = upq_pkg::STATUS_OK;
         scan_idx_in   = '0;
         if (req_tuser == upq_pkg::REQ_INSERT) begin
            if (count_ff == upq_pkg::CNT_W'(upq_pkg::CAPACITY)) begin
               res_status_in = upq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + upq_pkg::CNT_W'(1);
            end
         end else if (count_ff == '0) begin
            res_status_in = upq_pkg::STATUS_EMPTY;
         end
      end

      if (state_ff == upq_pkg::ST_SCAN) begin
         scan_idx_in = scan_idx_ff + upq_pkg::ADDR_W'(1);
      end

      // strict compare keeps the earliest of equal minima
      if (rd_valid_ff) begin
         if (rd_idx_ff == '0 || $signed(mem_rd_data) < best_ff) begin
            best_in     = $signed(mem_rd_data);
            best_idx_in = rd_idx_ff;
         end
         if (rd_idx_ff == last_idx) begin
            last_in = mem_rd_data;
         end
      end

      if (state_ff == upq_pkg::ST_WRITE) begin
         count_in     = count_ff - upq_pkg::CNT_W'(1);
         res_value_in = best_ff;
      end

      if (state_ff == upq_pkg::ST_DONE && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_value_in  = res_value_ff;
         rsp_count_in  = upq_pkg::ENTRY_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= upq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      last_ff       <= last_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = upq_pkg::RSP_DATA_W'({rsp_count_ff, rsp_value_ff});

endmodule

@@ rtl/upq_checker.sv @@
module upq_assertions (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [upq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [upq_pkg::STATUS_W-1:0]   rsp_tuser
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == upq_pkg::STATUS_EMPTY
      |-> rsp_tdata[upq_pkg::VALUE_W-1:0] == '0
          && rsp_tdata[upq_pkg::VALUE_W+upq_pkg::ENTRY_W-1:upq_pkg::VALUE_W] == '0)
      else $error("empty response with nonzero fields");

   a_full_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == upq_pkg::STATUS_FULL
      |-> rsp_tdata[upq_pkg::VALUE_W-1:0] == '0
          && rsp_tdata[upq_pkg::VALUE_W+upq_pkg::ENTRY_W-1:upq_pkg::VALUE_W]
             == upq_pkg::ENTRY_W'(upq_pkg::CAPACITY))
      else $error("full response with wrong count");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == upq_pkg::STATUS_OK || rsp_tuser == upq_pkg::STATUS_EMPTY
                     || rsp_tuser == upq_pkg::STATUS_FULL)
      else $error("undefined status code");

endmodule

bind unsorted_min_priority_queue_unit upq_assertions u_upq_assertions (.*);

@@ tb/upq_checker.sv @@
`timescale 1ns / 100ps

module upq_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [upq_pkg::VALUE_W-1:0]    req_tdata,   // item_value
   input  logic                           req_tuser,   // req_type
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [upq_pkg::RSP_DATA_W-1:0] rsp_tdata,   // min_value, entry_count, pad
   input  logic [upq_pkg::STATUS_W-1:0]   rsp_tuser,   // status
   output int                             fail_count,
   output int                             pending,
   output int                             full_seen,
   output int                             empty_seen,
   output int                             rsp_seen
);

   typedef struct packed {
      logic [upq_pkg::STATUS_W-1:0]       status;
      logic signed [upq_pkg::VALUE_W-1:0] min_value;
      logic [upq_pkg::ENTRY_W-1:0]        entry_count;
   } queue_rsp_type;

   logic signed [upq_pkg::VALUE_W-1:0] stored_vals [upq_pkg::CAPACITY];
   int                                 stored_count = 0;
   queue_rsp_type                      expected_rsps [$];
   int                                 errors = 0;
   int                                 rsps = 0;
   int                                 fulls = 0;
   int                                 empties = 0;

   function automatic queue_rsp_type apply_request(input logic kind,
                                                   input logic [upq_pkg::VALUE_W-1:0] value);
      queue_rsp_type r;
      int            best;
      r.status    = upq_pkg::STATUS_OK;
      r.min_value = '0;
      if (kind == upq_pkg::REQ_INSERT) begin
         if (stored_count >= upq_pkg::CAPACITY) begin
            r.status = upq_pkg::STATUS_FULL;
            fulls++;
         end else begin
            stored_vals[stored_count] = value;
            stored_count++;
         end
      end else if (stored_count == 0) begin
         r.status = upq_pkg::STATUS_EMPTY;
         empties++;
      end else begin
         // earliest slot wins a tie; last entry moves into the freed slot
         best = 0;
         for (int i = 1; i < stored_count; i++) begin
            if (stored_vals[i] < stored_vals[best]) begin
               best = i;
            end
         end
         r.min_value = stored_vals[best];
         stored_vals[best] = stored_vals[stored_count-1];
         stored_count--;
      end
      r.entry_count = upq_pkg::ENTRY_W'(stored_count);
      return r;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [upq_pkg::VALUE_W-1:0] want,
                                  input logic [upq_pkg::VALUE_W-1:0] got);
      if (errors < 60) begin
         $display("upq_checker: response %0d: %s expected %h got %h", rsps, what, want, got);
      end
      errors++;
   endtask

   always @(posedge clock) begin
      queue_rsp_type want;
      if (reset) begin
         stored_count = 0;
         expected_rsps.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(apply_request(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            rsps++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response, tdata", '0,
                               rsp_tdata[upq_pkg::VALUE_W-1:0]);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tuser != want.status) begin
                  report_mismatch("status", upq_pkg::VALUE_W'(want.status),
                                  upq_pkg::VALUE_W'(rsp_tuser));
               end
               if (rsp_tdata[upq_pkg::VALUE_W-1:0] != want.min_value) begin
                  report_mismatch("min_value", want.min_value,
                                  rsp_tdata[upq_pkg::VALUE_W-1:0]);
               end
               if (rsp_tdata[upq_pkg::VALUE_W+upq_pkg::ENTRY_W-1:upq_pkg::VALUE_W]
                   != want.entry_count) begin
                  report_mismatch("entry_count", upq_pkg::VALUE_W'(want.entry_count),
                                  upq_pkg::VALUE_W'(rsp_tdata[upq_pkg::VALUE_W+upq_pkg::ENTRY_W-1:
                                                              upq_pkg::VALUE_W]));
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= expected_rsps.size();
      full_seen  <= fulls;
      empty_seen <= empties;
      rsp_seen   <= rsps;
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 80;
   localparam int RANDOM_ITEMS = 450;

   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIX
   } mix_mode_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tuser  = upq_pkg::REQ_INSERT;
   logic [upq_pkg::VALUE_W-1:0]    req_tdata  = '0;
   logic                           rsp_tready = 1'b0;
   logic                           req_tready;
   logic                           rsp_tvalid;
   logic [upq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [upq_pkg::STATUS_W-1:0]   rsp_tuser;

   int fail_count;
   int pending;
   int full_seen;
   int empty_seen;
   int rsp_seen;

   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_asks     = 0;
   int holds_taken   = 0;
   int hold_left     = 0;
   int inserts_sent  = 0;
   int removes_sent  = 0;
   int cycles        = 0;

   logic [upq_pkg::VALUE_W-1:0] edge_vals [7] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                                  32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0005,
                                                  32'h0000_0005};

   unsorted_min_priority_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   upq_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending),
      .full_seen  (full_seen),
      .empty_seen (empty_seen),
      .rsp_seen   (rsp_seen)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // receiver: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_asks != holds_taken) begin
         holds_taken <= hold_asks;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top: timeout after %0d cycles, %0d responses pending", cycles, pending);
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic logic [upq_pkg::VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(19);
      if (sel == 0) begin
         return edge_vals[$urandom_range(3)];
      end else if (sel <= 4) begin
         return upq_pkg::VALUE_W'($urandom_range(8)) - upq_pkg::VALUE_W'(4);
      end
      return $urandom;
   endfunction

   task automatic send_req(input logic kind, input logic [upq_pkg::VALUE_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (kind == upq_pkg::REQ_INSERT) begin
         inserts_sent++;
      end else begin
         removes_sent++;
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      mix_mode_type mode;
      int           seg_left;
      logic         kind;

      mode     = MODE_MIX;
      seg_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // remove on empty, extremes, a tie, then drain past empty
      send_req(upq_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
      foreach (edge_vals[i]) begin
         send_req(upq_pkg::REQ_INSERT, edge_vals[i]);
      end
      repeat (8) send_req(upq_pkg::REQ_REMOVE, $urandom);
      wait_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ((n / 75) % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 49;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 49;
            end
            default: begin
               idle_pct  = 10;
               stall_pct = 10;
            end
         endcase
         if (n == 120 || n == 330) begin
            hold_asks++;
         end
         if (n == 225) begin
            wait_drained();
         end
         if (seg_left == 0) begin
            case (mode)
               MODE_MIX:   mode = MODE_FILL;
               MODE_FILL:  mode = MODE_DRAIN;
               default:    mode = MODE_MIX;
            endcase
            seg_left = (mode == MODE_MIX) ? 40 : 85;
         end
         seg_left--;
         case (mode)
            MODE_FILL:  kind = ($urandom_range(99) < 95) ? upq_pkg::REQ_INSERT
                                                          : upq_pkg::REQ_REMOVE;
            MODE_DRAIN: kind = ($urandom_range(99) < 95) ? upq_pkg::REQ_REMOVE
                                                          : upq_pkg::REQ_INSERT;
            default:    kind = ($urandom_range(1) == 0) ? upq_pkg::REQ_INSERT
                                                         : upq_pkg::REQ_REMOVE;
         endcase
         send_req(kind, (kind == upq_pkg::REQ_INSERT) ? pick_value()
                                                      : upq_pkg::VALUE_W'($urandom));
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("tb_top: %0d inserts and %0d remove-min requests sent, %0d responses checked",
               inserts_sent, removes_sent, rsp_seen);
      $display("tb_top: %0d inserts on a full queue, %0d removes on an empty queue",
               full_seen, empty_seen);
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
